// ===== rtl/hcrp_pkg.sv =====
// Shared types, codes and pattern helpers for the chunked response parser.
// No dependencies; every other file in rtl/ imports this package.
package hcrp_pkg;

    // Default width of the chunk size accumulator
    localparam int HCRP_CHUNK_SIZE_BITS = 32;

    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 24;
    localparam int KIND_W      = 3;
    localparam int STATUS_W    = 10;
    localparam int LINE_POS_W  = 5;

    localparam logic [STATUS_W-1:0]   STATUS_MAX = 10'd999;
    localparam logic [STATUS_W-1:0]   STATUS_OK  = 10'd200;
    localparam logic [LINE_POS_W-1:0] LINE_POS_MAX = 5'd31;
    localparam logic [LINE_POS_W-1:0] STATUS_PREFIX_LEN = 5'd9;
    localparam logic [LINE_POS_W-1:0] TE_PATTERN_LEN = 5'd26;
    localparam logic [LINE_POS_W-1:0] TE_WILDCARD_POS = 5'd18;
    localparam logic [LINE_POS_W-1:0] TE_MIN_LINE_LEN = 5'd27;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [8*9-1:0]  STATUS_PREFIX = "HTTP/1.1 ";
    localparam logic [8*26-1:0] TE_PATTERN    = "Transfer-Encoding: chunked";

    // Request opcode
    typedef enum logic {
        OP_START = 1'b0,
        OP_BYTE  = 1'b1
    } t_opcode;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        EV_PAYLOAD     = 3'd0,
        EV_CHUNK_DONE  = 3'd1,
        EV_COMPLETE    = 3'd2,
        EV_BAD_PROTO   = 3'd3,
        EV_UNSUPPORTED = 3'd4,
        EV_NOT_CHUNKED = 3'd5
    } t_event;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_CLOSED  = 6'b000001,
        PH_STATUS  = 6'b000010,
        PH_HEADERS = 6'b000100,
        PH_SIZE    = 6'b001000,
        PH_DATA    = 6'b010000,
        PH_TRAILER = 6'b100000
    } t_phase;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic                valid;
        t_event              kind;
        logic [7:0]          payload_byte;
        logic [STATUS_W-1:0] status_code;
    } t_result;

    // Expected byte of the status line prefix; zero past its end
    function automatic logic [7:0] status_prefix_char(input logic [LINE_POS_W-1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        if (pos < STATUS_PREFIX_LEN) begin
            c = STATUS_PREFIX[8*(8 - int'(pos)) +: 8];
        end
        return c;
    endfunction

    // Expected byte of the transfer-encoding header line; zero past its end
    function automatic logic [7:0] te_char(input logic [LINE_POS_W-1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        if (pos < TE_PATTERN_LEN) begin
            c = TE_PATTERN[8*(25 - int'(pos)) +: 8];
        end
        return c;
    endfunction

    // Hex digit decode: bit 4 flags a valid digit
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= "0" && b <= "9") begin
            r = {1'b1, 4'(b - "0")};
        end else if (b >= "a" && b <= "f") begin
            r = {1'b1, 4'(b - "a" + 8'd10)};
        end else if (b >= "A" && b <= "F") begin
            r = {1'b1, 4'(b - "A" + 8'd10)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/hcrp_in_reg.sv =====
// Input register stage of the chunked response parser.
// Depends on hcrp_pkg for the request item type.
module hcrp_in_reg
    import hcrp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // Take a new request whenever the held one moves on or none is held
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/hcrp_parser.sv =====
// Parser state and per-byte update logic of the chunked response parser.
// Depends on hcrp_pkg for types, codes and pattern helpers.
module hcrp_parser
    import hcrp_pkg::*;
#(
    parameter int CHUNK_SIZE_BITS = HCRP_CHUNK_SIZE_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    output t_result o_result
);

    localparam logic [CHUNK_SIZE_BITS-1:0] SIZE_ZERO = '0;
    localparam logic [CHUNK_SIZE_BITS-1:0] SIZE_ONE  = CHUNK_SIZE_BITS'(1);
    localparam logic [CHUNK_SIZE_BITS-1:0] SIZE_MAX  = '1;

    t_phase                    r_phase, n_phase;
    logic [LINE_POS_W-1:0]     r_line_pos, n_line_pos;
    logic                      r_mismatch, n_mismatch;
    logic                      r_cr_seen, n_cr_seen;
    logic                      r_line_empty, n_line_empty;
    logic [STATUS_W-1:0]       r_status, n_status;
    logic                      r_chunked, n_chunked;
    logic                      r_digits_done, n_digits_done;
    logic [CHUNK_SIZE_BITS-1:0] r_chunk_len, n_chunk_len;
    logic [CHUNK_SIZE_BITS-1:0] r_bytes_left, n_bytes_left;
    logic [1:0]                r_trailer_left, n_trailer_left;

    logic [7:0]                 b;
    logic                       line_end;
    logic [13:0]                status_acc;
    logic [4:0]                 hex;
    logic [CHUNK_SIZE_BITS+3:0] size_acc;
    logic [CHUNK_SIZE_BITS-1:0] bytes_dec;
    logic [1:0]                 trailer_dec;
    t_result                    res;

    assign b        = i_item.rx_byte;
    assign line_end = r_cr_seen && (b == CHAR_LF);
    assign status_acc = 14'(r_status) * 14'd10 + 14'(b - "0");
    assign hex      = hex_digit(b);
    assign size_acc = {r_chunk_len, hex[3:0]};
    assign bytes_dec   = (r_bytes_left != SIZE_ZERO) ? r_bytes_left - SIZE_ONE : SIZE_ZERO;
    assign trailer_dec = (r_trailer_left != 2'd0) ? r_trailer_left - 2'd1 : 2'd0;

    // Next-state and result for one request
    always_comb begin
        n_phase        = r_phase;
        n_line_pos     = r_line_pos;
        n_mismatch     = r_mismatch;
        n_cr_seen      = r_cr_seen;
        n_line_empty   = r_line_empty;
        n_status       = r_status;
        n_chunked      = r_chunked;
        n_digits_done  = r_digits_done;
        n_chunk_len    = r_chunk_len;
        n_bytes_left   = r_bytes_left;
        n_trailer_left = r_trailer_left;
        res            = '{valid: 1'b0, kind: EV_PAYLOAD, payload_byte: 8'd0,
                           status_code: '0};

        if (i_advance) begin
            if (i_item.opcode == OP_START) begin
                // Arm for a new reply, drop everything from the last one
                n_phase        = PH_STATUS;
                n_line_pos     = '0;
                n_mismatch     = 1'b0;
                n_cr_seen      = 1'b0;
                n_line_empty   = 1'b1;
                n_status       = '0;
                n_chunked      = 1'b0;
                n_digits_done  = 1'b0;
                n_chunk_len    = SIZE_ZERO;
                n_bytes_left   = SIZE_ZERO;
                n_trailer_left = 2'd0;
            end else begin
                case (r_phase)
                    PH_DATA: begin
                        n_bytes_left = bytes_dec;
                        if (bytes_dec == SIZE_ZERO) begin
                            n_phase        = PH_TRAILER;
                            n_trailer_left = 2'd2;
                        end
                        res.valid        = 1'b1;
                        res.kind         = EV_PAYLOAD;
                        res.payload_byte = b;
                    end
                    PH_TRAILER: begin
                        n_trailer_left = trailer_dec;
                        if (trailer_dec == 2'd0) begin
                            n_phase       = PH_SIZE;
                            n_chunk_len   = SIZE_ZERO;
                            n_line_pos    = '0;
                            n_mismatch    = 1'b0;
                            n_cr_seen     = 1'b0;
                            n_line_empty  = 1'b1;
                            n_digits_done = 1'b0;
                            res.valid     = 1'b1;
                            res.kind      = EV_CHUNK_DONE;
                        end
                    end
                    PH_STATUS, PH_HEADERS, PH_SIZE: begin
                        if (line_end) begin
                            // Line closes: decide on the whole line
                            n_line_pos    = '0;
                            n_mismatch    = 1'b0;
                            n_cr_seen     = 1'b0;
                            n_line_empty  = 1'b1;
                            n_digits_done = 1'b0;
                            if (r_phase == PH_STATUS) begin
                                if (r_mismatch) begin
                                    n_phase         = PH_CLOSED;
                                    res.valid       = 1'b1;
                                    res.kind        = EV_BAD_PROTO;
                                    res.status_code = r_status;
                                end else if (r_status != STATUS_OK) begin
                                    n_phase         = PH_CLOSED;
                                    res.valid       = 1'b1;
                                    res.kind        = EV_UNSUPPORTED;
                                    res.status_code = r_status;
                                end else begin
                                    n_phase = PH_HEADERS;
                                end
                            end else if (r_phase == PH_HEADERS) begin
                                if (r_line_empty) begin
                                    if (!r_chunked) begin
                                        n_phase         = PH_CLOSED;
                                        res.valid       = 1'b1;
                                        res.kind        = EV_NOT_CHUNKED;
                                        res.status_code = r_status;
                                    end else begin
                                        n_phase     = PH_SIZE;
                                        n_chunk_len = SIZE_ZERO;
                                    end
                                end else if (!r_mismatch && r_line_pos >= TE_MIN_LINE_LEN) begin
                                    n_chunked = 1'b1;
                                end
                            end else begin
                                // Size line done; line state is left as is
                                n_line_pos    = r_line_pos;
                                n_mismatch    = r_mismatch;
                                n_cr_seen     = r_cr_seen;
                                n_line_empty  = r_line_empty;
                                n_digits_done = r_digits_done;
                                if (r_chunk_len == SIZE_ZERO) begin
                                    n_phase   = PH_CLOSED;
                                    res.valid = 1'b1;
                                    res.kind  = EV_COMPLETE;
                                end else begin
                                    n_bytes_left = r_chunk_len;
                                    n_phase      = PH_DATA;
                                end
                            end
                        end else begin
                            // Ordinary line byte
                            if (r_phase == PH_STATUS) begin
                                if (r_line_pos < STATUS_PREFIX_LEN) begin
                                    if (b != status_prefix_char(r_line_pos)) begin
                                        n_mismatch = 1'b1;
                                    end
                                end else if (!r_mismatch && !r_digits_done) begin
                                    if (b >= "0" && b <= "9") begin
                                        n_status = (status_acc > 14'(STATUS_MAX)) ?
                                                   STATUS_MAX : status_acc[STATUS_W-1:0];
                                    end else begin
                                        n_digits_done = 1'b1;
                                    end
                                end
                            end else if (r_phase == PH_HEADERS) begin
                                if (r_line_pos < TE_PATTERN_LEN && r_line_pos != TE_WILDCARD_POS
                                        && b != te_char(r_line_pos)) begin
                                    n_mismatch = 1'b1;
                                end
                            end else if (!r_digits_done) begin
                                if (!hex[4]) begin
                                    n_digits_done = 1'b1;
                                end else if (size_acc[CHUNK_SIZE_BITS+3:CHUNK_SIZE_BITS] != 4'd0) begin
                                    n_chunk_len = SIZE_MAX;
                                end else begin
                                    n_chunk_len = size_acc[CHUNK_SIZE_BITS-1:0];
                                end
                            end
                            if (r_line_pos != '0 || b != CHAR_CR) begin
                                n_line_empty = 1'b0;
                            end
                            n_cr_seen = (b == CHAR_CR);
                            if (r_line_pos < LINE_POS_MAX) begin
                                n_line_pos = r_line_pos + 5'd1;
                            end
                        end
                    end
                    default: begin
                        // Closed: bytes are dropped
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_CLOSED;
            r_line_pos     <= '0;
            r_mismatch     <= 1'b0;
            r_cr_seen      <= 1'b0;
            r_line_empty   <= 1'b1;
            r_status       <= '0;
            r_chunked      <= 1'b0;
            r_digits_done  <= 1'b0;
            r_chunk_len    <= SIZE_ZERO;
            r_bytes_left   <= SIZE_ZERO;
            r_trailer_left <= 2'd0;
        end else begin
            r_phase        <= n_phase;
            r_line_pos     <= n_line_pos;
            r_mismatch     <= n_mismatch;
            r_cr_seen      <= n_cr_seen;
            r_line_empty   <= n_line_empty;
            r_status       <= n_status;
            r_chunked      <= n_chunked;
            r_digits_done  <= n_digits_done;
            r_chunk_len    <= n_chunk_len;
            r_bytes_left   <= n_bytes_left;
            r_trailer_left <= n_trailer_left;
        end
    end

    assign o_result = res;

    // Payload events only come out of the data phase
    a_payload_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && res.kind == EV_PAYLOAD) |-> (r_phase == PH_DATA))
        else $error("payload event outside data phase");

    // A start request always lands in the status line phase
    a_start_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && i_item.opcode == OP_START) |=> (r_phase == PH_STATUS))
        else $error("start request did not arm parser");

    // Data phase always has bytes outstanding
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_bytes_left != SIZE_ZERO))
        else $error("data phase with no bytes left");

    // Status code stays within its saturation bound
    a_status_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_status <= STATUS_MAX)
        else $error("status code above saturation bound");

endmodule

// ===== rtl/hcrp_out_reg.sv =====
// Result register stage of the chunked response parser.
// Depends on hcrp_pkg for the result type.
module hcrp_out_reg
    import hcrp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,
    input  t_result                i_result,
    input  logic                   i_ready,
    output logic                   o_free,
    output logic                   o_valid,
    output logic [KIND_W-1:0]      o_kind,
    output logic [TDATA_OUT_W-1:0] o_data
);

    logic    r_valid;
    t_result r_result;

    // Slot can take a new result when empty or drained this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_advance && i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_advance && i_result.valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_result.kind;
    assign o_data  = {(TDATA_OUT_W - STATUS_W - 8)'(0), r_result.status_code,
                      r_result.payload_byte};

endmodule

// ===== rtl/http_chunked_response_parser.sv =====
// Chunked HTTP/1.1 response parser, one received byte per request.
// Path: a request is held in the input register, and its result is registered in the result
// register as the parser takes the request; a request with no result only updates state.
// Throughput: one request per cycle; a held result with tready low stalls the input side.
// Reset: synchronous active-low i_rst_n empties both stages and closes the parser.
// Depends on hcrp_pkg, hcrp_in_reg, hcrp_parser and hcrp_out_reg.
module http_chunked_response_parser
    import hcrp_pkg::*;
#(
    parameter int CHUNK_SIZE_BITS = HCRP_CHUNK_SIZE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]             i_s_axis_tuser,   // [0] opcode
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [TDATA_OUT_W-1:0] o_m_axis_tdata,   // [7:0] payload_byte, [17:8] status_code
    output logic [KIND_W-1:0]      o_m_axis_tuser    // [2:0] event_kind
);

    t_item   s_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_free;
    logic    advance;
    t_result result;

    assign s_item  = '{opcode: t_opcode'(i_s_axis_tuser[0]), rx_byte: i_s_axis_tdata};
    assign advance = held_valid && out_free;

    hcrp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_item    (s_item),
        .i_advance (advance),
        .o_ready   (o_s_axis_tready),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    hcrp_parser #(
        .CHUNK_SIZE_BITS (CHUNK_SIZE_BITS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (held_item),
        .o_result  (result)
    );

    hcrp_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_result  (result),
        .i_ready   (i_m_axis_tready),
        .o_free    (out_free),
        .o_valid   (o_m_axis_tvalid),
        .o_kind    (o_m_axis_tuser),
        .o_data    (o_m_axis_tdata)
    );

endmodule
